FILE: rtl/iaan_pkg.sv
// Shared types and constants for the IMU offset and normalize block.
// No dependencies; every other file imports this package.
package iaan_pkg;

  localparam int AXES = 3;
  localparam int SAMPLE_W = 16;
  localparam int DIFF_W = 17;
  localparam int MAG_W = 17;
  localparam int SQ_W = 34;
  localparam int SUM_W = 36;
  localparam int UNIT_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_Z = 3'd5;

  typedef struct packed {
    logic [AXES-1:0][DIFF_W-1:0] acc;
    logic [AXES-1:0][DIFF_W-1:0] rate;
  } item_t;

endpackage

FILE: rtl/iaan_front.sv
// Front end: calibration registers, offset subtraction and one item register.
// Depends on iaan_pkg.
module iaan_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [iaan_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iaan_pkg::SAMPLE_W-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [6*iaan_pkg::SAMPLE_W-1:0]    in_data,
  output logic                               item_valid,
  input  logic                               item_ready,
  output iaan_pkg::item_t                    item
);
  import iaan_pkg::*;

  logic [5:0][SAMPLE_W-1:0] off_r;
  logic                     fv_r;
  item_t                    item_r;
  item_t                    item_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ACCEL_X: off_r[0] <= cfg_data;
        CFG_ACCEL_Y: off_r[1] <= cfg_data;
        CFG_ACCEL_Z: off_r[2] <= cfg_data;
        CFG_GYRO_X:  off_r[3] <= cfg_data;
        CFG_GYRO_Y:  off_r[4] <= cfg_data;
        CFG_GYRO_Z:  off_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      item_nxt.acc[i] = DIFF_W'(signed'(in_data[i*SAMPLE_W +: SAMPLE_W]))
                      - DIFF_W'(signed'(off_r[i]));
      item_nxt.rate[i] = DIFF_W'(signed'(in_data[(i+3)*SAMPLE_W +: SAMPLE_W]))
                       - DIFF_W'(signed'(off_r[i+3]));
    end
  end

  assign in_ready = !fv_r || item_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = fv_r;
  assign item = item_r;

endmodule

FILE: rtl/iaan_queue.sv
// Short FIFO between the front end and the normalize pipeline.
// Depends on iaan_pkg.
module iaan_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  iaan_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output iaan_pkg::item_t pop_item
);
  import iaan_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [PW-1:0]  wp_r;
  logic [PW-1:0]  rp_r;
  logic [CW-1:0]  cnt_r;
  logic           push;
  logic           pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule

FILE: rtl/iaan_back.sv
// Normalize pipeline: squares, sum of squares, one quotient bit per stage
// by exact square comparison, sign and output register. Depends on iaan_pkg.
module iaan_back #(
  parameter int FB = 14
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      item_valid,
  output logic                                      item_ready,
  input  iaan_pkg::item_t                           item,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [iaan_pkg::AXES-1:0][iaan_pkg::UNIT_W-1:0] out_unit,
  output logic [iaan_pkg::AXES-1:0][iaan_pkg::DIFF_W-1:0] out_rate,
  output logic                                      out_zero
);
  import iaan_pkg::*;

  localparam int NS = FB + 1;
  localparam int QW = FB + 1;
  localparam int TW = SUM_W + QW;
  localparam int WW = 2 * FB + 38;
  localparam int XW = FB + 18;

  logic en;

  logic                               p1v_r;
  logic [AXES-1:0][SQ_W-1:0]          p1sq_r;
  logic [AXES-1:0]                    p1neg_r;
  logic [AXES-1:0][DIFF_W-1:0]        p1rate_r;

  logic                               v_r    [NS+1];
  logic [SUM_W-1:0]                   s_r    [NS+1];
  logic                               z_r    [NS+1];
  logic [AXES-1:0]                    neg_r  [NS+1];
  logic [AXES-1:0][DIFF_W-1:0]        rate_r [NS+1];
  logic [AXES-1:0][WW-1:0]            rem_r  [NS+1];
  logic [AXES-1:0][TW-1:0]            t_r    [NS+1];
  logic [AXES-1:0][QW-1:0]            q_r    [NS+1];

  logic                               ov_r;
  logic [AXES-1:0][UNIT_W-1:0]        unit_r;
  logic [AXES-1:0][UNIT_W-1:0]        unit_nxt;
  logic [AXES-1:0][DIFF_W-1:0]        orate_r;
  logic                               oz_r;

  assign en = !ov_r || out_ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1v_r <= 1'b0;
      v_r[0] <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      p1v_r <= item_valid;
      v_r[0] <= p1v_r;
      ov_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        logic [MAG_W-1:0] mag;
        mag = item.acc[i][DIFF_W-1] ? MAG_W'(-item.acc[i]) : MAG_W'(item.acc[i]);
        p1sq_r[i] <= SQ_W'(mag * mag);
        p1neg_r[i] <= item.acc[i][DIFF_W-1];
      end
      p1rate_r <= item.rate;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0] <= SUM_W'(p1sq_r[0]) + SUM_W'(p1sq_r[1]) + SUM_W'(p1sq_r[2]);
      z_r[0] <= (p1sq_r == '0);
      neg_r[0] <= p1neg_r;
      rate_r[0] <= p1rate_r;
      for (int i = 0; i < AXES; i++) begin
        rem_r[0][i] <= WW'(p1sq_r[i]) << (2 * FB);
        t_r[0][i] <= '0;
        q_r[0][i] <= '0;
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_bit
    localparam int B = FB - k;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k+1] <= s_r[k];
        z_r[k+1] <= z_r[k];
        neg_r[k+1] <= neg_r[k];
        rate_r[k+1] <= rate_r[k];
        for (int i = 0; i < AXES; i++) begin
          logic [WW-1:0] incr;
          incr = (WW'(t_r[k][i]) << (B + 1)) + (WW'(s_r[k]) << (2 * B));
          if (incr <= rem_r[k][i]) begin
            rem_r[k+1][i] <= rem_r[k][i] - incr;
            t_r[k+1][i] <= t_r[k][i] + (TW'(s_r[k]) << B);
            q_r[k+1][i] <= q_r[k][i] | (QW'(1) << B);
          end else begin
            rem_r[k+1][i] <= rem_r[k][i];
            t_r[k+1][i] <= t_r[k][i];
            q_r[k+1][i] <= q_r[k][i];
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      logic [XW-1:0] qx;
      logic [XW-1:0] sx;
      qx = XW'(q_r[NS][i]);
      sx = neg_r[NS][i] ? (XW'(0) - qx) : qx;
      unit_nxt[i] = z_r[NS] ? '0 : sx[UNIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= unit_nxt;
      orate_r <= rate_r[NS];
      oz_r <= z_r[NS];
    end
  end

  assign out_valid = ov_r;
  assign out_unit = unit_r;
  assign out_rate = orate_r;
  assign out_zero = oz_r;

endmodule

FILE: rtl/imu_offset_and_accel_normalize.sv
// Top level of the IMU offset correction and acceleration normalize block.
// Instantiates iaan_front, iaan_queue and iaan_back; uses iaan_pkg.
//
// Channel  Direction  Contents
// in_      slave      accel x/y/z, gyro x/y/z (16 bit signed each)
// out_     master     unit x/y/z, rate x/y/z, zero_magnitude flag in tuser
// cfg_     slave      offset register index and 16-bit value
//
// One sample is accepted per cycle unless the queue is full; the quotient
// pipeline resolves one bit per stage.
// Reset clears the offsets to zero and empties every stage and the queue.
// An output stall freezes the pipeline; the queue keeps the input side moving until it fills.
module imu_offset_and_accel_normalize #(
  parameter int OUTPUT_FRACTION_BITS = 14,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [iaan_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iaan_pkg::SAMPLE_W-1:0]       cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [95:0]                         in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // unit_x, unit_y, unit_z, rate_x, rate_y, rate_z, zero padding
  output logic [103:0]                        out_tdata,
  // zero_magnitude
  output logic [0:0]                          out_tuser
);
  import iaan_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;
  logic [AXES-1:0][UNIT_W-1:0] unit;
  logic [AXES-1:0][DIFF_W-1:0] rate;
  logic zero;

  iaan_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata),
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  iaan_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_item(q_item)
  );

  iaan_back #(.FB(OUTPUT_FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_unit(unit), .out_rate(rate), .out_zero(zero)
  );

  assign out_tdata = {5'b0, rate, unit};
  assign out_tuser = zero;

`ifndef SYNTHESIS
  a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[47:0] == 48'd0)
    else $error("zero magnitude with nonzero unit components");

  a_nonzero_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[47:0] != 48'd0)
    else $error("nonzero vector normalized to all zero components");
`endif

endmodule
